// ===== rtl/mlbt_pkg.sv =====
// mlbt_pkg: shared constants, types and hash function for the bridge table
// no dependencies
package mlbt_pkg;

  localparam int BUCKETS = 1024;
  localparam int WAYS = 8;
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_W = 64;
  localparam int PORT_W = 5;
  // one row holds all ways of a bucket: key and port per way (valid bits sit in their own memory)
  localparam int WAY_BITS = KEY_W + PORT_W;
  localparam int ROW_W = WAYS * WAY_BITS;

  localparam logic [1:0] LS_KNOWN = 2'd0;
  localparam logic [1:0] LS_NEW = 2'd1;
  localparam logic [1:0] LS_FULL = 2'd2;

  typedef struct packed {
    logic load;      // capture input item
    logic rd_src;    // read bucket of source key
    logic rd_dst;    // read bucket of destination key
    logic learn;     // evaluate source row and write if new
    logic resolve;   // evaluate destination row, fill output
    logic clr_wr;    // write clearing pass row
  } mlbt_cmd_t;

  typedef struct packed {
    logic clr_done;
  } mlbt_sts_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [31:0] h;
    h = 32'd0;
    for (int i = 0; i < 4; i++) begin
      h = (h << 5) + h + {16'd0, key[16*i +: 16]};
    end
    return h[BKT_W-1:0];
  endfunction

endpackage

// ===== rtl/mlbt_ram.sv =====
// mlbt_ram: generic single port ram with registered read
// no dependencies
module mlbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/mlbt_datapath.sv =====
// mlbt_datapath: input registers, bucket memories, way match and result registers
// depends on mlbt_pkg, mlbt_ram
module mlbt_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mlbt_pkg::mlbt_cmd_t        cmd,
  output mlbt_pkg::mlbt_sts_t        sts,
  input  logic [4:0]                 in_port,
  input  logic [15:0]                in_bridge_id,
  input  logic [47:0]                in_src_mac,
  input  logic [47:0]                in_dst_mac,
  output logic [4:0]                 out_port,
  output logic                       out_flood,
  output logic [1:0]                 out_learn_status
);
  logic [4:0] port_r;
  logic [mlbt_pkg::KEY_W-1:0] skey_r, dkey_r;
  logic [mlbt_pkg::BKT_W-1:0] sbkt_r, dbkt_r, clr_r;
  logic [mlbt_pkg::WAYS-1:0] vld_rd;
  logic [mlbt_pkg::ROW_W-1:0] row_rd;
  logic [mlbt_pkg::WAYS-1:0] vwr;
  logic [mlbt_pkg::ROW_W-1:0] rwr;
  logic [mlbt_pkg::BKT_W-1:0] addr;
  logic we;
  logic [4:0] oport_r;
  logic oflood_r;
  logic [1:0] ostat_r;

  assign out_port = oport_r;
  assign out_flood = oflood_r;
  assign out_learn_status = ostat_r;
  assign sts.clr_done = (clr_r == mlbt_pkg::BKT_W'(mlbt_pkg::BUCKETS - 1));

  // way match on registered row
  logic [mlbt_pkg::WAYS-1:0] hit;
  logic [mlbt_pkg::KEY_W-1:0] cmp_key;
  logic any_hit, any_free;
  logic [mlbt_pkg::WAY_W-1:0] free_way;
  logic [4:0] hit_port;
  assign cmp_key = cmd.resolve ? dkey_r : skey_r;

  always_comb begin
    any_hit = 1'b0;
    any_free = 1'b0;
    free_way = '0;
    hit_port = '0;
    for (int w = 0; w < mlbt_pkg::WAYS; w++) begin
      hit[w] = vld_rd[w] &&
               row_rd[w*mlbt_pkg::WAY_BITS +: mlbt_pkg::KEY_W] == cmp_key;
      if (hit[w]) begin
        any_hit = 1'b1;
        hit_port = row_rd[w*mlbt_pkg::WAY_BITS + mlbt_pkg::KEY_W +: 5];
      end
    end
    for (int w = mlbt_pkg::WAYS - 1; w >= 0; w--) begin
      if (!vld_rd[w]) begin
        any_free = 1'b1;
        free_way = mlbt_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    vwr = vld_rd;
    rwr = row_rd;
    we = 1'b0;
    addr = sbkt_r;
    if (cmd.clr_wr) begin
      we = 1'b1;
      vwr = '0;
      addr = clr_r;
    end else if (cmd.learn) begin
      we = !any_hit && any_free;
      vwr[free_way] = 1'b1;
      rwr[free_way*mlbt_pkg::WAY_BITS +: mlbt_pkg::WAY_BITS] = {port_r, skey_r};
    end else if (cmd.rd_dst) begin
      addr = dbkt_r;
    end
  end

  // write-first bypass is unneeded: dst row is read the cycle after the write
  mlbt_ram #(.WIDTH(mlbt_pkg::WAYS), .DEPTH(mlbt_pkg::BUCKETS)) u_vld (
    .clk, .we, .addr, .wdata(vwr), .rdata(vld_rd));
  mlbt_ram #(.WIDTH(mlbt_pkg::ROW_W), .DEPTH(mlbt_pkg::BUCKETS)) u_row (
    .clk, .we(we && !cmd.clr_wr), .addr, .wdata(rwr), .rdata(row_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      port_r <= in_port;
      skey_r <= {in_bridge_id, in_src_mac};
      dkey_r <= {in_bridge_id, in_dst_mac};
      sbkt_r <= mlbt_pkg::bucket_of({in_bridge_id, in_src_mac});
      dbkt_r <= mlbt_pkg::bucket_of({in_bridge_id, in_dst_mac});
    end
    if (cmd.learn) begin
      ostat_r <= any_hit ? mlbt_pkg::LS_KNOWN :
                 any_free ? mlbt_pkg::LS_NEW : mlbt_pkg::LS_FULL;
    end
    if (cmd.resolve) begin
      oflood_r <= !any_hit;
      oport_r <= any_hit ? hit_port : 5'd0;
    end
  end
endmodule

// ===== rtl/mlbt_ctrl.sv =====
// mlbt_ctrl: sequencer for clear pass, learn and destination lookup
// depends on mlbt_pkg
module mlbt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mlbt_pkg::mlbt_cmd_t cmd,
  input  mlbt_pkg::mlbt_sts_t sts
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RDS = 3'd2,
                         S_LRN = 3'd3, S_RDD = 3'd4, S_RES = 3'd5;
  logic [2:0] state_r, state_nxt;
  logic ovld_r, ovld_nxt;
  logic take;

  assign out_valid = ovld_r;
  assign in_stall = !(state_r == S_IDLE) || (ovld_r && out_stall);
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ovld_nxt = ovld_r && out_stall;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd.load = 1'b1;
          state_nxt = S_RDS;
        end
      end
      S_RDS: begin
        cmd.rd_src = 1'b1;
        state_nxt = S_LRN;
      end
      S_LRN: begin
        cmd.learn = 1'b1;
        state_nxt = S_RDD;
      end
      // dest row read after the learn write has landed
      S_RDD: begin
        cmd.rd_dst = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        cmd.resolve = 1'b1;
        ovld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r <= ovld_nxt;
    end
  end
endmodule

// ===== rtl/mac_learning_bridge_table.sv =====
// mac_learning_bridge_table: layer-2 learn and forward table
// depends on mlbt_pkg, mlbt_ctrl, mlbt_datapath
// each frame steps through load, source row read, learn write, dest row read, resolve;
// a new frame is taken only after resolve, and the result waits in an output register
// reset: synchronous active low; a clearing pass writes one bucket row a cycle,
// covering all 1024 buckets, with in_stall high until it ends
module mac_learning_bridge_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_port,
  input  logic [15:0] in_bridge_id,
  input  logic [47:0] in_src_mac,
  input  logic [47:0] in_dst_mac,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_port,
  output logic        out_flood,
  output logic [1:0]  out_learn_status
);
  mlbt_pkg::mlbt_cmd_t cmd, cmd_dp;
  mlbt_pkg::mlbt_sts_t sts;

  mlbt_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .sts);

  // commands go straight to the datapath; the dest row read has its own cycle
  // after the learn write, so it always sees the freshly learned entry
  always_comb begin
    cmd_dp = cmd;
  end

  mlbt_datapath u_dp (.clk, .rst_n, .cmd(cmd_dp), .sts, .in_port, .in_bridge_id,
    .in_src_mac, .in_dst_mac, .out_port, .out_flood, .out_learn_status);
endmodule

// ===== rtl/mlbt_checker.sv =====
// mlbt_checker: port level assertions for the bridge table
// depends on mac_learning_bridge_table ports
module mlbt_checker (
  input logic clk, rst_n, in_valid, in_stall, out_valid, out_stall,
  input logic [4:0] out_port,
  input logic out_flood,
  input logic [1:0] out_learn_status
);
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_learn_status != 2'd3) else $error("bad status");
  a_flood: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flood |-> out_port == 5'd0) else $error("flood port");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_port))
    else $error("held result");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("back to back");
endmodule

bind mac_learning_bridge_table mlbt_checker u_chk (.*);

// ===== dv/testbench.sv =====
// testbench for mac_learning_bridge_table: directed frames then random learn/forward traffic
// depends on mlbt_pkg and the rtl of mac_learning_bridge_table; self-checking against
// an in-bench model of the bucketed table
`timescale 1ns / 1ps
module testbench;

  localparam int TBL_SIZE = mlbt_pkg::BUCKETS * mlbt_pkg::WAYS;
  localparam int WDOG_LIMIT = 20000;
  localparam int RAND_FRAMES = 1830;

  typedef struct packed {
    logic [4:0]  port;
    logic [15:0] brid;
    logic [47:0] src;
    logic [47:0] dst;
  } frame_t;

  typedef struct packed {
    logic [4:0] port;
    logic       flood;
    logic [1:0] status;
  } fwd_t;

  // directed row: frame plus optional typed-in expectation
  typedef struct packed {
    frame_t f;
    logic   has_exp;
    fwd_t   e;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [4:0] in_port;
  logic [15:0] in_bridge_id;
  logic [47:0] in_src_mac, in_dst_mac;
  logic out_valid, out_stall;
  logic [4:0] out_port;
  logic out_flood;
  logic [1:0] out_learn_status;

  mac_learning_bridge_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_port(in_port), .in_bridge_id(in_bridge_id),
    .in_src_mac(in_src_mac), .in_dst_mac(in_dst_mac),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_port(out_port), .out_flood(out_flood), .out_learn_status(out_learn_status)
  );

  // shadow copy of the table
  bit          shadow_valid [TBL_SIZE];
  logic [63:0] shadow_key [TBL_SIZE];
  logic [4:0]  shadow_port [TBL_SIZE];

  fwd_t pending_fwd [$];
  int   errors = 0;
  int   idle_cycles = 0;

  // pool of recently used keys so lookups hit and buckets fill
  logic [47:0] mac_pool [$];
  logic [15:0] brid_pool [$];

  function automatic logic [9:0] hash_bucket(logic [63:0] key);
    logic [31:0] h;
    h = 0;
    for (int i = 0; i < 4; i++) h = h * 33 + key[16*i +: 16];
    return h[9:0];
  endfunction

  function automatic int find_key(logic [63:0] key);
    int base;
    base = hash_bucket(key) * mlbt_pkg::WAYS;
    for (int w = 0; w < mlbt_pkg::WAYS; w++)
      if (shadow_valid[base+w] && shadow_key[base+w] === key) return base + w;
    return -1;
  endfunction

  // learn source then forward on destination
  function automatic fwd_t learn_and_forward(frame_t f);
    fwd_t r;
    logic [63:0] skey, dkey;
    int base, hit;
    skey = {f.brid, f.src};
    dkey = {f.brid, f.dst};
    if (find_key(skey) >= 0) r.status = mlbt_pkg::LS_KNOWN;
    else begin
      r.status = mlbt_pkg::LS_FULL;
      base = hash_bucket(skey) * mlbt_pkg::WAYS;
      for (int w = 0; w < mlbt_pkg::WAYS; w++)
        if (!shadow_valid[base+w]) begin
          shadow_valid[base+w] = 1;
          shadow_key[base+w] = skey;
          shadow_port[base+w] = f.port;
          r.status = mlbt_pkg::LS_NEW;
          break;
        end
    end
    hit = find_key(dkey);
    if (hit >= 0) begin
      r.port = shadow_port[hit];
      r.flood = 0;
    end else begin
      r.port = 0;
      r.flood = 1;
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: random stalls, compare against oldest expectation
  initial begin
    int gap;
    out_stall = 1;
    @(posedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      // transfer happened at this edge
      if (pending_fwd.size() == 0) begin
        $error("result with nothing expected: port %0d flood %0d status %0d",
               out_port, out_flood, out_learn_status);
        errors++;
      end else begin
        fwd_t e;
        e = pending_fwd.pop_front();
        if (out_flood !== e.flood) begin
          $error("out_flood expected %0d actual %0d", e.flood, out_flood); errors++;
        end
        if (out_port !== e.port) begin
          $error("out_port expected %0d actual %0d", e.port, out_port); errors++;
        end
        if (out_learn_status !== e.status) begin
          $error("out_learn_status expected %0d actual %0d", e.status, out_learn_status);
          errors++;
        end
      end
    end
  end

  task automatic send_frame(frame_t f, bit has_exp, fwd_t e);
    fwd_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_port <= f.port;
    in_bridge_id <= f.brid;
    in_src_mac <= f.src;
    in_dst_mac <= f.dst;
    do @(posedge clk); while (in_stall);
    p = learn_and_forward(f);
    if (has_exp && p !== e) begin
      $error("predictor disagrees with directed row: expected %h got %h", e, p);
      errors++;
    end
    pending_fwd.push_back(p);
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // pick a pooled mac, a fresh random one, or one of a small set of low values
  function automatic logic [47:0] pick_mac();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && mac_pool.size() > 0) return mac_pool[$urandom_range(0, mac_pool.size()-1)];
    if (sel < 7) return {38'd0, 2'($urandom_range(0, 3)), 8'(sel)};
    return rand_mac();
  endfunction

  initial begin
    dir_row_t dir_rows [$];
    frame_t f;
    fwd_t none;
    none = '0;
    in_valid = 0; in_port = 0; in_bridge_id = 0; in_src_mac = 0; in_dst_mac = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed rows: empty table, extremes, self forward, known on new port
    dir_rows.push_back('{'{5'd0, 16'h0000, 48'h0, 48'h0}, 1'b1,
                         '{5'd0, 1'b0, mlbt_pkg::LS_NEW}});
    dir_rows.push_back('{'{5'd31, 16'hffff, 48'hffffffffffff, 48'h123456789abc}, 1'b1,
                         '{5'd0, 1'b1, mlbt_pkg::LS_NEW}});
    dir_rows.push_back('{'{5'd7, 16'hffff, 48'hffffffffffff, 48'hffffffffffff}, 1'b1,
                         '{5'd31, 1'b0, mlbt_pkg::LS_KNOWN}});
    dir_rows.push_back('{'{5'd3, 16'h0000, 48'h0, 48'hffffffffffff}, 1'b1,
                         '{5'd0, 1'b1, mlbt_pkg::LS_KNOWN}});
    dir_rows.push_back('{'{5'd9, 16'h0001, 48'h0, 48'h0}, 1'b1,
                         '{5'd9, 1'b0, mlbt_pkg::LS_NEW}});
    dir_rows.push_back('{'{5'd21, 16'haaaa, 48'haaaaaaaaaaaa, 48'h555555555555}, 1'b0, none});
    dir_rows.push_back('{'{5'd10, 16'h5555, 48'h555555555555, 48'haaaaaaaaaaaa}, 1'b0, none});
    // same bucket: keys differing only in high word by multiples of 1024 collide
    for (int i = 0; i < 10; i++)
      dir_rows.push_back('{'{5'(i), 16'h0000, {48'(i) << 42} ^ 48'h00000000abcd, 48'h0}, 1'b0,
                           none});
    dir_rows.push_back('{'{5'd1, 16'h0000, 48'h1 << 42 ^ 48'habcd, 48'habcd}, 1'b0, none});
    dir_rows.push_back('{'{5'd2, 16'h0000, 48'h9 << 42 ^ 48'habcd, 48'h9 << 42 ^ 48'habcd},
                         1'b0, none});

    foreach (dir_rows[i]) send_frame(dir_rows[i].f, dir_rows[i].has_exp, dir_rows[i].e);

    for (int n = 0; n < RAND_FRAMES; n++) begin
      // hold off once until the pipe drains
      if (n == RAND_FRAMES / 2) begin
        in_valid <= 0;
        wait (pending_fwd.size() == 0);
      end
      f.port = 5'($urandom_range(0, 31));
      f.brid = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
               (brid_pool.size() > 0 ? brid_pool[$urandom_range(0, brid_pool.size()-1)] :
                16'($urandom_range(0, 3)));
      f.src = pick_mac();
      f.dst = pick_mac();
      if (mac_pool.size() < 64) mac_pool.push_back(f.src);
      else mac_pool[$urandom_range(0, 63)] = f.src;
      if (brid_pool.size() < 4) brid_pool.push_back(f.brid);
      send_frame(f, 1'b0, none);
    end
    in_valid <= 0;

    wait (pending_fwd.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule

// ===== mac_learning_bridge_table.f =====
rtl/mlbt_pkg.sv
rtl/mlbt_ram.sv
rtl/mlbt_datapath.sv
rtl/mlbt_ctrl.sv
rtl/mac_learning_bridge_table.sv
rtl/mlbt_checker.sv
dv/testbench.sv
